/* src/pms_pkg.sv */
// Shared types, codes and constants for the motif scanner.
package pms_pkg;

  localparam int MAX_WINDOW_DEF  = 32;
  localparam int ALPHABET_DEF    = 5;
  localparam int WEIGHT_BITS_DEF = 16;
  localparam int POS_BITS_DEF    = 20;

  localparam int CMD_W       = 2;
  localparam int COLUMN_W    = 5;
  localparam int SYMBOL_W    = 3;
  localparam int WEIGHT_IN_W = 16;
  localparam int SCORE_W     = 24;
  localparam int WLEN_W      = 6;
  localparam int OFFSET_W    = 8;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 24;

  // result buffer depth: room for one judgement in flight plus two words waiting
  localparam int HIT_FIFO_DEPTH = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_WEIGHT = 2'd0,
    CMD_LOAD_MASK   = 2'd1,
    CMD_BASE        = 2'd2
  } cmd_e_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_WINDOW_LENGTH   = 2'd0,
    CFG_MARK_OFFSET     = 2'd1,
    CFG_SCORE_THRESHOLD = 2'd2,
    CFG_MASK_ENABLE     = 2'd3
  } cfg_idx_e_t;

  // broadcast from the front end to every cell
  typedef struct packed {
    logic                   shift;
    logic                   first;
    logic [SYMBOL_W-1:0]    code;
    logic                   load_weight;
    logic                   load_mask;
    logic [COLUMN_W-1:0]    column;
    logic [SYMBOL_W-1:0]    symbol;
    logic [WEIGHT_IN_W-1:0] weight;
  } cell_ctrl_t;

  // one open window as it moves from cell to cell
  typedef struct packed {
    logic                      valid;
    logic                      ok;
    logic signed [SCORE_W-1:0] sum;
  } cell_link_t;

endpackage

/* src/pms_in_if.sv */
// Input channel: load and base words with valid/ready.
interface pms_in_if;
  import pms_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [CMD_W-1:0]       cmd;
  logic [COLUMN_W-1:0]    column;
  logic [SYMBOL_W-1:0]    symbol;
  logic [WEIGHT_IN_W-1:0] weight;
  logic [SYMBOL_W-1:0]    base_code;
  logic                   first_base;

  modport source (output valid, cmd, column, symbol, weight, base_code, first_base,
                  input ready);
  modport sink (input valid, cmd, column, symbol, weight, base_code, first_base,
                output ready);
endinterface

/* src/pms_out_if.sv */
// Result channel: hit position and score with valid/ready.
interface pms_out_if #(
  parameter int POS_BITS = pms_pkg::POS_BITS_DEF
);
  import pms_pkg::*;

  logic                        valid;
  logic                        ready;
  logic signed [POS_BITS+1:0]  hit_position;
  logic signed [SCORE_W-1:0]   hit_score;

  modport source (output valid, hit_position, hit_score, input ready);
  modport sink (input valid, hit_position, hit_score, output ready);
endinterface

/* src/pwm_motif_scanner_core.sv */
// Top level of the position weight matrix scanner: front end, cell row, judge, result buffer.
//
// The scanner takes one word per clock while its input is ready: a weight load, a mask
// load or a sequence base. Every column of the matrix is a cell in a row; a base adds
// its weight into the window held by each cell and the windows shift one cell along,
// so the motif length does not slow the base stream. The window reaching column
// window_length - 1 is judged in the next cycle and a hit enters a three-word
// result buffer, which feeds the output channel. Input ready drops only while that
// buffer and the judgement in flight fill all three slots, which happens only when the
// output side stalls. No clearing pass after reset: the weight table is not cleared
// and must be loaded before use.
module pwm_motif_scanner_core #(
  parameter int MAX_WINDOW  = pms_pkg::MAX_WINDOW_DEF,
  parameter int ALPHABET    = pms_pkg::ALPHABET_DEF,
  parameter int WEIGHT_BITS = pms_pkg::WEIGHT_BITS_DEF,
  parameter int POS_BITS    = pms_pkg::POS_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  pms_in_if.sink                           in_ch,
  pms_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [pms_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [pms_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import pms_pkg::*;

  localparam int IW  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int PSW = POS_BITS + 2;
  localparam int HW  = PSW + SCORE_W;
  localparam int FCW = $clog2(HIT_FIFO_DEPTH + 1);

  // configuration
  logic [WLEN_W-1:0]         wlen_r;
  logic signed [OFFSET_W-1:0] offset_r;
  logic signed [SCORE_W-1:0]  thr_r;
  logic                       mask_en_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r    <= WLEN_W'(1);
      offset_r  <= '0;
      thr_r     <= '0;
      mask_en_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx_e_t'(cfg_index))
        CFG_WINDOW_LENGTH:   wlen_r    <= cfg_data[WLEN_W-1:0];
        CFG_MARK_OFFSET:     offset_r  <= cfg_data[OFFSET_W-1:0];
        CFG_SCORE_THRESHOLD: thr_r     <= cfg_data[SCORE_W-1:0];
        CFG_MASK_ENABLE:     mask_en_r <= cfg_data[0];
        default:             ;
      endcase
    end
  end

  // front end
  logic               in_acc, is_base, base_take;
  logic [POS_BITS:0]  cnt_r, cnt_nxt, cnt_eff;
  cell_ctrl_t         ctrl;
  logic [FCW-1:0]     fifo_cnt;
  logic               pend_r;
  logic [POS_BITS-1:0] pend_pos_r;

  assign in_ch.ready = (int'(fifo_cnt) + int'(pend_r)) < HIT_FIFO_DEPTH;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign is_base     = in_acc && (in_ch.cmd == CMD_BASE);

  always_comb begin
    cnt_eff   = in_ch.first_base ? '0 : cnt_r;
    // past the position range bases are dropped until the next sequence
    base_take = is_base && !cnt_eff[POS_BITS];
    cnt_nxt   = cnt_r;
    if (base_take)
      cnt_nxt = cnt_eff + (POS_BITS+1)'(1);

    ctrl.shift       = base_take;
    ctrl.first       = in_ch.first_base;
    ctrl.code        = in_ch.base_code;
    ctrl.load_weight = in_acc && (in_ch.cmd == CMD_LOAD_WEIGHT);
    ctrl.load_mask   = in_acc && (in_ch.cmd == CMD_LOAD_MASK);
    ctrl.column      = in_ch.column;
    ctrl.symbol      = in_ch.symbol;
    ctrl.weight      = in_ch.weight;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      pend_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      pend_r <= base_take;
    end
  end

  always_ff @(posedge clk) begin
    if (base_take)
      pend_pos_r <= cnt_eff[POS_BITS-1:0];
  end

  // cell row
  cell_link_t link [MAX_WINDOW];

  for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
    cell_link_t link_in;
    if (k == 0) begin : g_head
      assign link_in = '0;
    end else begin : g_body
      assign link_in = link[k-1];
    end
    pms_cell #(
      .COL         (k),
      .ALPHABET    (ALPHABET),
      .WEIGHT_BITS (WEIGHT_BITS)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctrl_i (ctrl),
      .link_i (link_in),
      .link_o (link[k])
    );
  end

  // judge: the cells still hold the last base's windows during this cycle
  logic [IW-1:0]          sel_idx;
  cell_link_t             sel;
  logic                   hit_push;
  logic signed [PSW-1:0]  hit_pos;
  logic [HW-1:0]          fifo_data;

  always_comb begin
    if (wlen_r == '0)
      sel_idx = '0;
    else if (int'(wlen_r) > MAX_WINDOW)
      sel_idx = IW'(MAX_WINDOW - 1);
    else
      sel_idx = IW'(wlen_r - WLEN_W'(1));

    sel      = link[sel_idx];
    hit_push = pend_r && sel.valid && (!mask_en_r || sel.ok) && (sel.sum >= thr_r);
    hit_pos  = $signed({2'b00, pend_pos_r}) - $signed(PSW'(sel_idx)) + PSW'(offset_r);
  end

  pms_hit_fifo #(
    .WIDTH (HW),
    .DEPTH (HIT_FIFO_DEPTH)
  ) u_hit_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (hit_push),
    .data_i  ({hit_pos, sel.sum}),
    .count_o (fifo_cnt),
    .valid_o (out_ch.valid),
    .ready_i (out_ch.ready),
    .data_o  (fifo_data)
  );

  assign out_ch.hit_position = fifo_data[HW-1:SCORE_W];
  assign out_ch.hit_score    = fifo_data[SCORE_W-1:0];

  // checks
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    hit_push |-> (int'(fifo_cnt) < HIT_FIFO_DEPTH))
    else $error("hit buffer overflow");

  a_pend_source: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> $past(base_take))
    else $error("judgement without a base");

  a_head_open: assert property (@(posedge clk) disable iff (!rst_n)
    base_take |=> link[0].valid)
    else $error("head cell did not open a window");

endmodule

/* src/pms_cell.sv */
// One matrix column: local weights and conserved base, adds into the passing window.
module pms_cell #(
  parameter int COL         = 0,
  parameter int ALPHABET    = pms_pkg::ALPHABET_DEF,
  parameter int WEIGHT_BITS = pms_pkg::WEIGHT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  pms_pkg::cell_ctrl_t ctrl_i,
  input  pms_pkg::cell_link_t link_i,
  output pms_pkg::cell_link_t link_o
);
  import pms_pkg::*;

  localparam int WS  = (WEIGHT_BITS < WEIGHT_IN_W) ? WEIGHT_BITS : WEIGHT_IN_W;
  localparam int AW  = $clog2(ALPHABET);
  localparam int UNK = ALPHABET - 1;

  logic signed [WS-1:0]      wt_r [ALPHABET];
  logic [SYMBOL_W-1:0]       req_r;
  cell_link_t                link_r, link_nxt, src;
  logic [AW-1:0]             code_c;
  logic signed [WS-1:0]      w_sel;
  logic signed [SCORE_W:0]   sum_wide;
  logic signed [SCORE_W-1:0] sum_sat;
  logic                      mismatch;

  always_ff @(posedge clk) begin
    if (ctrl_i.load_weight && int'(ctrl_i.column) == COL && int'(ctrl_i.symbol) < ALPHABET)
      wt_r[AW'(ctrl_i.symbol)] <= ctrl_i.weight[WS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_r <= SYMBOL_W'(UNK);
    end else if (ctrl_i.load_mask && int'(ctrl_i.column) == COL) begin
      req_r <= ctrl_i.symbol;
    end
  end

  always_comb begin
    code_c = (int'(ctrl_i.code) > UNK) ? AW'(UNK) : AW'(ctrl_i.code);
    w_sel  = wt_r[code_c];

    // column 0 always opens a fresh window; a new sequence drops the rest
    if (COL == 0) begin
      src = '{valid: 1'b1, ok: 1'b1, sum: '0};
    end else if (ctrl_i.first) begin
      src = '0;
    end else begin
      src = link_i;
    end

    sum_wide = (SCORE_W+1)'(src.sum) + (SCORE_W+1)'(w_sel);
    if (sum_wide[SCORE_W] != sum_wide[SCORE_W-1])
      sum_sat = sum_wide[SCORE_W] ? {1'b1, {(SCORE_W-1){1'b0}}} : {1'b0, {(SCORE_W-1){1'b1}}};
    else
      sum_sat = sum_wide[SCORE_W-1:0];

    // unknown base never meets a constraint
    mismatch = (int'(req_r) < UNK) && ((int'(code_c) >= UNK) || (code_c != AW'(req_r)));

    link_nxt       = link_r;
    link_nxt.valid = src.valid;
    link_nxt.ok    = src.ok && !mismatch;
    link_nxt.sum   = sum_sat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_r.valid <= 1'b0;
    end else if (ctrl_i.shift) begin
      link_r <= link_nxt;
    end
  end

  assign link_o = link_r;

endmodule

/* src/pms_hit_fifo.sv */
// Small result buffer between the judgement stage and the output channel.
module pms_hit_fifo #(
  parameter int WIDTH = 46,
  parameter int DEPTH = pms_pkg::HIT_FIFO_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           data_i,
  output logic [$clog2(DEPTH+1)-1:0] count_o,
  output logic                       valid_o,
  input  logic                       ready_i,
  output logic [WIDTH-1:0]           data_o
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             pop;

  assign pop = valid_o && ready_i;

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push_i)
      wr_nxt = (int'(wr_r) == DEPTH - 1) ? '0 : wr_r + PW'(1);
    if (pop)
      rd_nxt = (int'(rd_r) == DEPTH - 1) ? '0 : rd_r + PW'(1);
    if (push_i && !pop)
      cnt_nxt = cnt_r + CW'(1);
    else if (!push_i && pop)
      cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i)
      mem_r[wr_r] <= data_i;
  end

  assign valid_o = (cnt_r != '0);
  assign data_o  = mem_r[rd_r];
  assign count_o = cnt_r;

endmodule
